// File: hdl/ltv_pkg.sv
// Shared constants, stage counts and rounding helpers for the look-to view matrix block.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package ltv_pkg;

    // Axis format is Q2.30.
    localparam int AXIS_FRAC = 30;

    // Magnitude width inside the normalizer (inputs stay within 2^62).
    localparam int MAG_W = 63;

    // Pipeline geometry of one normalizer.
    localparam int SHIFT_STEPS = 6;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 31;
    localparam int MP_DEPTH    = SQRT_STAGES + 3;
    localparam int NORM_LAT    = 2 + SHIFT_STEPS + 3 + SQRT_STAGES + 1 + DIV_STAGES + 1;

    // Beat widths.
    localparam int IN_W  = 288;
    localparam int OUT_W = 384;

    localparam logic [30:0] AXIS_ONE_Q = 31'h4000_0000;
    localparam logic signed [63:0] AXIS_MAX  = 64'sh0000_0000_4000_0000;
    localparam logic signed [63:0] AXIS_MIN  = -64'sh0000_0000_4000_0000;
    localparam logic signed [63:0] WORD_MAX  = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] WORD_MIN  = -64'sh0000_0000_8000_0000;

    // Magnitude of a signed word that is known to stay within 2^62.
    function automatic logic [MAG_W-1:0] mag63(input logic signed [63:0] v);
        logic [63:0] t;
        t = v[63] ? (64'd0 - v) : v;
        return t[MAG_W-1:0];
    endfunction

    // Shift right by the axis fraction, rounding half away from zero.
    function automatic logic signed [63:0] rnd30(input logic signed [63:0] x);
        logic [63:0] m;
        m = x[63] ? (64'd0 - x) : x;
        m = (m + (64'd1 << (AXIS_FRAC - 1))) >> AXIS_FRAC;
        return x[63] ? $signed(64'd0 - m) : $signed(m);
    endfunction

    // Clamp to the unit range of an axis component.
    function automatic logic [31:0] clamp_axis(input logic signed [63:0] x);
        logic signed [63:0] t;
        if (x > AXIS_MAX) begin
            t = AXIS_MAX;
        end else if (x < AXIS_MIN) begin
            t = AXIS_MIN;
        end else begin
            t = x;
        end
        return t[31:0];
    endfunction

    // Saturate to a 32-bit signed word.
    function automatic logic [31:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] t;
        if (x > WORD_MAX) begin
            t = WORD_MAX;
        end else if (x < WORD_MIN) begin
            t = WORD_MIN;
        end else begin
            t = x;
        end
        return t[31:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/ltv_sqrt.sv
// Pipelined integer square root, one result bit per stage (floor of the root).
// Depends on ltv_pkg for the stage count.
`default_nettype none

module ltv_sqrt import ltv_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [63:0] rad,
    output logic      [31:0] root
);

    logic [34:0] rem_reg  [SQRT_STAGES];
    logic [31:0] root_reg [SQRT_STAGES];
    logic [63:0] rad_reg  [SQRT_STAGES];

    // Each stage brings down two radicand bits and decides one root bit.
    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [34:0] prem;
        logic [31:0] proot;
        logic [63:0] prad;
        logic [34:0] acc;
        logic [34:0] trial;
        logic        fit;

        if (k == 0) begin : g_first
            assign prem  = '0;
            assign proot = '0;
            assign prad  = rad;
        end else begin : g_rest
            assign prem  = rem_reg[k-1];
            assign proot = root_reg[k-1];
            assign prad  = rad_reg[k-1];
        end

        assign acc   = {prem[32:0], prad[63:62]};
        assign trial = {1'b0, proot, 2'b01};
        assign fit   = (acc >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= fit ? (acc - trial) : acc;
                root_reg[k] <= {proot[30:0], fit};
                rad_reg[k]  <= {prad[61:0], 2'b00};
            end
        end
    end

    assign root = root_reg[SQRT_STAGES-1];

endmodule

`default_nettype wire

// File: hdl/ltv_div.sv
// Three-lane pipelined restoring divider sharing one divisor, one quotient bit per stage.
// Depends on ltv_pkg; the caller guarantees the top numerator half is below the divisor.
`default_nettype none

module ltv_div import ltv_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [61:0] num [3],
    input  wire logic [31:0] den,
    output logic      [30:0] quo [3]
);

    logic [31:0] rem_reg [DIV_STAGES][3];
    logic [30:0] quo_reg [DIV_STAGES][3];
    logic [30:0] low_reg [DIV_STAGES][3];
    logic [31:0] den_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [31:0] pden;

        if (k == 0) begin : g_den0
            assign pden = den;
        end else begin : g_denk
            assign pden = den_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[k] <= pden;
            end
        end

        // One partial remainder step per lane.
        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [31:0] prem;
            logic [30:0] pquo;
            logic [30:0] plow;
            logic [32:0] acc;
            logic        fit;

            if (k == 0) begin : g_first
                assign prem = {1'b0, num[l][61:31]};
                assign pquo = '0;
                assign plow = num[l][30:0];
            end else begin : g_rest
                assign prem = rem_reg[k-1][l];
                assign pquo = quo_reg[k-1][l];
                assign plow = low_reg[k-1][l];
            end

            assign acc = {prem, plow[30]};
            assign fit = (acc >= {1'b0, pden});

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k][l] <= fit ? 32'(acc - {1'b0, pden}) : acc[31:0];
                    quo_reg[k][l] <= {pquo[29:0], fit};
                    low_reg[k][l] <= {plow[29:0], 1'b0};
                end
            end
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_out
        assign quo[l] = quo_reg[DIV_STAGES-1][l];
    end

endmodule

`default_nettype wire

// File: hdl/ltv_norm.sv
// Vector normalizer pipeline: block shift, sum of squares, square root, three divides.
// Depends on ltv_pkg, ltv_sqrt and ltv_div; carries a side payload at the same latency.
`default_nettype none

module ltv_norm import ltv_pkg::*; #(
    parameter int SB_W = 192
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic signed [63:0]     in_vec [3],
    input  wire logic        [SB_W-1:0] in_side,
    output logic                        out_valid,
    output logic             [31:0]     out_vec [3],
    output logic             [SB_W-1:0] out_side
);

    localparam int SIDE_W = SB_W + 4;

    logic              vld_reg  [NORM_LAT];
    logic [SIDE_W-1:0] side_reg [NORM_LAT];

    logic [MAG_W-1:0] abs_reg [3];
    logic [MAG_W-1:0] sh_mx_reg  [SHIFT_STEPS+1];
    logic [MAG_W-1:0] sh_m_reg   [SHIFT_STEPS+1][3];
    logic             sh_big_reg [SHIFT_STEPS+1];
    logic [31:0]      mp_reg [MP_DEPTH][3];
    logic [63:0]      sq_reg [3];
    logic [63:0]      sum_reg;
    logic [31:0]      root;
    logic [61:0]      num_reg [3];
    logic [31:0]      den_reg;
    logic [30:0]      quo [3];
    logic [31:0]      out_reg [3];

    logic             in_zero;
    logic [MAG_W-1:0] mx01;
    logic [MAG_W-1:0] mx;
    logic             sel_hi;
    logic [SIDE_W-1:0] fin_side;

    // Valid bits travel alongside the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NORM_LAT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < NORM_LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Side line: zero flag, component signs and the caller's payload.
    assign in_zero = (in_vec[0] == 64'sd0) && (in_vec[1] == 64'sd0) && (in_vec[2] == 64'sd0);

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= {in_zero, in_vec[2][63], in_vec[1][63], in_vec[0][63], in_side};
            for (int k = 1; k < NORM_LAT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Magnitudes, then the largest of them.
    assign mx01 = (abs_reg[0] > abs_reg[1]) ? abs_reg[0] : abs_reg[1];
    assign mx   = (mx01 > abs_reg[2]) ? mx01 : abs_reg[2];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                abs_reg[l]     <= mag63(in_vec[l]);
                sh_m_reg[0][l] <= abs_reg[l];
            end
            sh_mx_reg[0]  <= mx;
            sh_big_reg[0] <= (mx[MAG_W-1:31] != '0);
        end
    end

    // Left-justify the block in halving shift steps.
    for (genvar k = 1; k <= SHIFT_STEPS; k++) begin : g_shift
        localparam int AMT = 64 >> k;
        logic go;

        assign go = (sh_mx_reg[k-1][MAG_W-1 -: AMT] == '0);

        always_ff @(posedge aclk) begin
            if (en) begin
                sh_mx_reg[k]  <= go ? (sh_mx_reg[k-1] << AMT) : sh_mx_reg[k-1];
                sh_big_reg[k] <= sh_big_reg[k-1];
                for (int l = 0; l < 3; l++) begin
                    sh_m_reg[k][l] <= go ? (sh_m_reg[k-1][l] << AMT) : sh_m_reg[k-1][l];
                end
            end
        end
    end

    // A large vector that truncates exactly to 2^31 keeps the top window; all
    // others take the window that places the maximum in [2^30, 2^31).
    assign sel_hi = sh_big_reg[SHIFT_STEPS] && (sh_mx_reg[SHIFT_STEPS][61:31] == '0);

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                mp_reg[0][l] <= sel_hi ? sh_m_reg[SHIFT_STEPS][l][62:31]
                                       : {1'b0, sh_m_reg[SHIFT_STEPS][l][62:32]};
                for (int k = 1; k < MP_DEPTH; k++) begin
                    mp_reg[k][l] <= mp_reg[k-1][l];
                end
            end
        end
    end

    // Squares and their sum feed the root.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                sq_reg[l] <= mp_reg[0][l] * mp_reg[0][l];
            end
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    ltv_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (sum_reg),
        .root (root)
    );

    // Scaled numerators with half the divisor added for rounding.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                num_reg[l] <= {mp_reg[MP_DEPTH-1][l], 30'd0} + {31'd0, root[31:1]};
            end
            den_reg <= root;
        end
    end

    ltv_div u_div (
        .aclk (aclk),
        .en   (en),
        .num  (num_reg),
        .den  (den_reg),
        .quo  (quo)
    );

    // Clamp, restore the sign, and force zero for a zero-length vector.
    assign fin_side = side_reg[NORM_LAT-2];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                if (fin_side[SB_W+3]) begin
                    out_reg[l] <= '0;
                end else if (fin_side[SB_W+l]) begin
                    out_reg[l] <= 32'd0 - {1'b0, (quo[l] > AXIS_ONE_Q) ? AXIS_ONE_Q : quo[l]};
                end else begin
                    out_reg[l] <= {1'b0, (quo[l] > AXIS_ONE_Q) ? AXIS_ONE_Q : quo[l]};
                end
            end
        end
    end

    assign out_valid = vld_reg[NORM_LAT-1];
    assign out_side  = side_reg[NORM_LAT-1][SB_W-1:0];
    for (genvar l = 0; l < 3; l++) begin : g_out
        assign out_vec[l] = out_reg[l];
    end

endmodule

`default_nettype wire

// File: hdl/look_to_view_matrix.sv
// Look-to view matrix (left-handed): camera axes in Q2.30 and translation row in Q16.16.
// Depends on ltv_pkg and ltv_norm (which uses ltv_sqrt and ltv_div).
//
// One camera is taken per beat and one result beat comes out per camera, in order. The
// pipeline is two normalizers of 76 stages each (forward axis, then right
// axis), two stages for the cross product up x forward, three for the up axis and three
// for the offsets. The depth is set by the square root and the dividers inside each
// normalizer, which resolve one bit per stage. A new beat is accepted every cycle while
// the result side takes beats; when m_tready is low with a result waiting, the whole
// pipeline holds and s_tready falls in the same cycle. A zero look vector yields an
// all-zero result; an up vector that is zero or parallel to the look vector yields zero
// right and up axes and zero x and y offsets.
`default_nettype none

module look_to_view_matrix import ltv_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // eye_x, eye_y, eye_z, look_x, look_y, look_z, up_x, up_y, up_z (32 bits each)
    input  wire logic [IN_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // right_x/y/z, upward_x/y/z, forward_x/y/z, offset_x/y/z (32 bits each)
    output logic      [OUT_W-1:0]  m_tdata
);

    logic en;

    logic signed [63:0] look_ext [3];
    logic [191:0]       n1_side_in;
    logic               n1_valid;
    logic [31:0]        fwd1 [3];
    logic [191:0]       n1_side;
    logic signed [31:0] up1 [3];

    logic signed [63:0] pc_reg [6];
    logic [95:0]        c1_eye_reg;
    logic [31:0]        c1_fwd_reg [3];
    logic signed [63:0] rc_reg [3];
    logic [95:0]        c2_eye_reg;
    logic [31:0]        c2_fwd_reg [3];

    logic               n2_valid;
    logic [31:0]        rgt2 [3];
    logic [191:0]       n2_side_in;
    logic [191:0]       n2_side;
    logic signed [31:0] fwd2 [3];

    logic signed [63:0] pu_reg [6];
    logic [31:0]        u1_eye_reg [3];
    logic [31:0]        u1_fwd_reg [3];
    logic [31:0]        u1_rgt_reg [3];
    logic signed [63:0] tmp_reg [3];
    logic [31:0]        u2_eye_reg [3];
    logic [31:0]        u2_fwd_reg [3];
    logic [31:0]        u2_rgt_reg [3];
    logic [31:0]        upa_reg [3];
    logic [31:0]        u3_eye_reg [3];
    logic [31:0]        u3_fwd_reg [3];
    logic [31:0]        u3_rgt_reg [3];

    logic signed [63:0] po_reg [9];
    logic [31:0]        o1_axis_reg [9];
    logic signed [63:0] dot_reg [3];
    logic [31:0]        o2_axis_reg [9];
    logic [31:0]        out_axis_reg [9];
    logic [31:0]        off_reg [3];

    logic               vld_reg [8];

    // The pipeline moves as one unit whenever the output register can advance.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Forward axis: normalize the look vector; eye and up ride along.
    for (genvar l = 0; l < 3; l++) begin : g_look
        assign look_ext[l] = {{32{s_tdata[96+32*l+31]}}, s_tdata[96+32*l +: 32]};
    end
    assign n1_side_in = {s_tdata[287:192], s_tdata[95:0]};

    ltv_norm #(.SB_W(192)) u_norm_fwd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_vec    (look_ext),
        .in_side   (n1_side_in),
        .out_valid (n1_valid),
        .out_vec   (fwd1),
        .out_side  (n1_side)
    );

    for (genvar l = 0; l < 3; l++) begin : g_up1
        assign up1[l] = n1_side[96+32*l +: 32];
    end

    // Cross product up x forward: products, then differences.
    always_ff @(posedge aclk) begin
        if (en) begin
            pc_reg[0] <= up1[1] * $signed(fwd1[2]);
            pc_reg[1] <= up1[2] * $signed(fwd1[1]);
            pc_reg[2] <= up1[2] * $signed(fwd1[0]);
            pc_reg[3] <= up1[0] * $signed(fwd1[2]);
            pc_reg[4] <= up1[0] * $signed(fwd1[1]);
            pc_reg[5] <= up1[1] * $signed(fwd1[0]);
            c1_eye_reg <= n1_side[95:0];
            c2_eye_reg <= c1_eye_reg;
            for (int l = 0; l < 3; l++) begin
                c1_fwd_reg[l] <= fwd1[l];
                c2_fwd_reg[l] <= c1_fwd_reg[l];
                rc_reg[l]     <= pc_reg[2*l] - pc_reg[2*l+1];
            end
        end
    end

    // Right axis: normalize the cross product; eye and forward ride along.
    assign n2_side_in = {c2_fwd_reg[2], c2_fwd_reg[1], c2_fwd_reg[0], c2_eye_reg};

    ltv_norm #(.SB_W(192)) u_norm_rgt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld_reg[1]),
        .in_vec    (rc_reg),
        .in_side   (n2_side_in),
        .out_valid (n2_valid),
        .out_vec   (rgt2),
        .out_side  (n2_side)
    );

    for (genvar l = 0; l < 3; l++) begin : g_fwd2
        assign fwd2[l] = n2_side[96+32*l +: 32];
    end

    // Up axis: forward x right, rounded to Q2.30 and clamped.
    always_ff @(posedge aclk) begin
        if (en) begin
            pu_reg[0] <= fwd2[1] * $signed(rgt2[2]);
            pu_reg[1] <= fwd2[2] * $signed(rgt2[1]);
            pu_reg[2] <= fwd2[2] * $signed(rgt2[0]);
            pu_reg[3] <= fwd2[0] * $signed(rgt2[2]);
            pu_reg[4] <= fwd2[0] * $signed(rgt2[1]);
            pu_reg[5] <= fwd2[1] * $signed(rgt2[0]);
            for (int l = 0; l < 3; l++) begin
                u1_eye_reg[l] <= n2_side[32*l +: 32];
                u1_fwd_reg[l] <= fwd2[l];
                u1_rgt_reg[l] <= rgt2[l];
                tmp_reg[l]    <= pu_reg[2*l] - pu_reg[2*l+1];
                u2_eye_reg[l] <= u1_eye_reg[l];
                u2_fwd_reg[l] <= u1_fwd_reg[l];
                u2_rgt_reg[l] <= u1_rgt_reg[l];
                upa_reg[l]    <= clamp_axis(rnd30(tmp_reg[l]));
                u3_eye_reg[l] <= u2_eye_reg[l];
                u3_fwd_reg[l] <= u2_fwd_reg[l];
                u3_rgt_reg[l] <= u2_rgt_reg[l];
            end
        end
    end

    // Offsets: dot products with the eye, negated, rounded and saturated.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                po_reg[l]        <= $signed(u3_rgt_reg[l]) * $signed(u3_eye_reg[l]);
                po_reg[3+l]      <= $signed(upa_reg[l]) * $signed(u3_eye_reg[l]);
                po_reg[6+l]      <= $signed(u3_fwd_reg[l]) * $signed(u3_eye_reg[l]);
                o1_axis_reg[l]   <= u3_rgt_reg[l];
                o1_axis_reg[3+l] <= upa_reg[l];
                o1_axis_reg[6+l] <= u3_fwd_reg[l];
                dot_reg[l]       <= po_reg[3*l] + po_reg[3*l+1] + po_reg[3*l+2];
                off_reg[l]       <= sat32(rnd30(64'sd0 - dot_reg[l]));
            end
            for (int k = 0; k < 9; k++) begin
                o2_axis_reg[k]  <= o1_axis_reg[k];
                out_axis_reg[k] <= o2_axis_reg[k];
            end
        end
    end

    // Valid bits of the stages outside the normalizers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 8; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= n1_valid;
            vld_reg[1] <= vld_reg[0];
            vld_reg[2] <= n2_valid;
            for (int k = 3; k < 8; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Result beat.
    assign m_tvalid = vld_reg[7];
    for (genvar k = 0; k < 9; k++) begin : g_axis_out
        assign m_tdata[32*k +: 32] = out_axis_reg[k];
    end
    for (genvar l = 0; l < 3; l++) begin : g_off_out
        assign m_tdata[288+32*l +: 32] = off_reg[l];
    end

    // A zero forward axis leaves nothing else standing.
    a_zero_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[287:192] == '0) |-> (m_tdata == '0))
        else $error("nonzero result with a zero forward axis");

    // A zero right axis forces a zero up axis and a zero x offset.
    a_zero_right: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[95:0] == '0) |-> (m_tdata[191:96] == '0 && m_tdata[319:288] == '0))
        else $error("up axis or x offset nonzero with a zero right axis");

    // The forward_x axis component stays within the unit range.
    a_fwd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[223:192]) <= 32'sh4000_0000 &&
                      $signed(m_tdata[223:192]) >= -32'sh4000_0000))
        else $error("forward_x outside the unit range");

endmodule

`default_nettype wire
